FILE: sv/varg_pkg.sv
// Shared types, widths, register codes and action codes for the voice
// activity record gate. No dependencies; every other file uses this package.
package varg_pkg;

  // Frame sizing.
  localparam int MAX_FRAME_LEN = 1024;
  localparam int IDX_W = $clog2(MAX_FRAME_LEN);
  localparam int CNT_W = IDX_W + 1;
  localparam int LEN_W = 11;
  localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int MAG_W = SAMPLE_W + 1;
  localparam int ENERGY_W = 26;
  localparam int CROSS_W = 10;
  localparam int COUNT_W = 8;
  localparam int CFG_DATA_W = 26;
  localparam int CFG_IDX_W = 3;

  // Saturation limits.
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [CROSS_W-1:0] CROSS_MAX = {CROSS_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Register reset values.
  localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = 11'd256;
  localparam logic [ENERGY_W-1:0] ENERGY_THR_RST = 26'd100000;
  localparam logic [CROSS_W-1:0] CROSS_THR_RST = 10'd10;
  localparam logic [COUNT_W-1:0] SILENCE_END_RST = 8'd3;
  localparam logic [COUNT_W-1:0] MIN_RECORD_RST = 8'd5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH = 3'd0,
    REG_ENERGY_THR   = 3'd1,
    REG_CROSS_THR    = 3'd2,
    REG_SILENCE_END  = 3'd3,
    REG_MIN_RECORD   = 3'd4
  } cfg_reg_t;

  // Result actions.
  typedef enum logic [1:0] {
    ACT_IDLE     = 2'd0,
    ACT_WRITE    = 2'd1,
    ACT_FINALIZE = 2'd2,
    ACT_DISCARD  = 2'd3
  } action_t;

  // Recording state, one-hot.
  typedef enum logic [2:0] {
    ST_SILENT    = 3'b001,
    ST_RECORDING = 3'b010,
    ST_ENDED     = 3'b100
  } rec_state_t;

  typedef struct packed {
    logic [LEN_W-1:0]    frame_length;
    logic [ENERGY_W-1:0] energy_thr;
    logic [CROSS_W-1:0]  cross_thr;
    logic [COUNT_W-1:0]  silence_end;
    logic [COUNT_W-1:0]  min_record;
  } cfg_t;

  // Frame totals as seen after the current sample.
  typedef struct packed {
    logic                done;
    logic [ENERGY_W-1:0] energy;
    logic [CROSS_W-1:0]  crossings;
  } frame_sum_t;

  typedef struct packed {
    action_t             action;
    logic                voiced;
    logic [ENERGY_W-1:0] energy;
    logic [CROSS_W-1:0]  crossings;
    logic [COUNT_W-1:0]  recorded;
  } result_t;

endpackage

FILE: sv/varg_frame_acc.sv
// Per-frame accumulator: absolute sum, sign change count and sample position.
// Depends on varg_pkg.
module varg_frame_acc (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  logic signed [varg_pkg::SAMPLE_W-1:0]  sample,
  input  logic [varg_pkg::LEN_W-1:0]            frame_length,
  output varg_pkg::frame_sum_t                  frame
);

  logic [varg_pkg::IDX_W-1:0]    sample_index;
  logic [varg_pkg::ENERGY_W-1:0] energy_sum;
  logic [varg_pkg::CROSS_W-1:0]  crossing_sum;
  logic [varg_pkg::SAMPLE_W-1:0] previous_sample;

  logic [varg_pkg::MAG_W-1:0]    mag;
  logic [varg_pkg::ENERGY_W:0]   energy_wide;
  logic [varg_pkg::ENERGY_W-1:0] energy_next;
  logic [varg_pkg::CROSS_W-1:0]  crossing_next;
  logic                          sign_change;
  logic [varg_pkg::CNT_W-1:0]    index_inc;
  logic [varg_pkg::CMP_W-1:0]    len_ext;
  logic [varg_pkg::CMP_W-1:0]    eff_len;

  // Magnitude of the sample; the most negative value gives 2^15.
  assign mag = sample[varg_pkg::SAMPLE_W-1]
             ? (varg_pkg::MAG_W'(0) - {sample[varg_pkg::SAMPLE_W-1], sample})
             : {1'b0, sample};

  // Saturating energy sum.
  assign energy_wide = {1'b0, energy_sum} + (varg_pkg::ENERGY_W+1)'(mag);
  assign energy_next = energy_wide[varg_pkg::ENERGY_W] ? varg_pkg::ENERGY_MAX
                                                       : energy_wide[varg_pkg::ENERGY_W-1:0];

  // A strict sign change needs both samples non-zero and opposite in sign,
  // and is never counted against the previous frame's last sample.
  always_comb begin
    sign_change = 1'b0;
    if (sample_index != '0) begin
      sign_change = (!sample[varg_pkg::SAMPLE_W-1] && (sample != '0)
                     && previous_sample[varg_pkg::SAMPLE_W-1])
                 || (sample[varg_pkg::SAMPLE_W-1] && !previous_sample[varg_pkg::SAMPLE_W-1]
                     && (previous_sample != '0));
    end
  end

  assign crossing_next = (sign_change && (crossing_sum != varg_pkg::CROSS_MAX))
                       ? crossing_sum + 1'b1 : crossing_sum;

  // Effective frame length, clamped to the supported range.
  assign len_ext = varg_pkg::CMP_W'(frame_length);
  always_comb begin
    if (len_ext < varg_pkg::CMP_W'(2)) begin
      eff_len = varg_pkg::CMP_W'(2);
    end else if (len_ext > varg_pkg::CMP_W'(varg_pkg::MAX_FRAME_LEN)) begin
      eff_len = varg_pkg::CMP_W'(varg_pkg::MAX_FRAME_LEN);
    end else begin
      eff_len = len_ext;
    end
  end

  assign index_inc = varg_pkg::CNT_W'(sample_index) + 1'b1;

  always_comb begin
    frame.done      = varg_pkg::CMP_W'(index_inc) >= eff_len;
    frame.energy    = energy_next;
    frame.crossings = crossing_next;
  end

  // Accumulators clear at each frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      energy_sum      <= '0;
      crossing_sum    <= '0;
      previous_sample <= '0;
    end else if (step) begin
      if (frame.done) begin
        sample_index    <= '0;
        energy_sum      <= '0;
        crossing_sum    <= '0;
        previous_sample <= '0;
      end else begin
        sample_index    <= index_inc[varg_pkg::IDX_W-1:0];
        energy_sum      <= energy_next;
        crossing_sum    <= crossing_next;
        previous_sample <= sample;
      end
    end
  end

endmodule

FILE: sv/varg_rec_fsm.sv
// Recording state machine, advanced once per finished frame; forms the result.
// Depends on varg_pkg.
module varg_rec_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  varg_pkg::frame_sum_t frame,
  input  varg_pkg::cfg_t       cfg,
  output varg_pkg::result_t    result
);

  varg_pkg::rec_state_t          record_state;
  varg_pkg::rec_state_t          record_state_next;
  varg_pkg::rec_state_t          mid_state;
  logic [varg_pkg::COUNT_W-1:0]  silent_run;
  logic [varg_pkg::COUNT_W-1:0]  silent_run_next;
  logic [varg_pkg::COUNT_W-1:0]  run_mid;
  logic [varg_pkg::COUNT_W-1:0]  record_count;
  logic [varg_pkg::COUNT_W-1:0]  record_count_next;
  logic                          voiced;

  assign voiced = (frame.energy > cfg.energy_thr) && (frame.crossings > cfg.cross_thr);

  // Voiced or silent update first.
  always_comb begin
    if (voiced) begin
      mid_state = varg_pkg::ST_RECORDING;
      run_mid   = '0;
    end else begin
      run_mid   = (silent_run != varg_pkg::COUNT_MAX) ? silent_run + 1'b1 : silent_run;
      mid_state = record_state;
      if ((record_state == varg_pkg::ST_RECORDING) && (run_mid > cfg.silence_end)) begin
        mid_state = varg_pkg::ST_ENDED;
      end
    end
  end

  // Then the action for the frame and the state left behind.
  always_comb begin
    record_state_next = varg_pkg::ST_SILENT;
    silent_run_next   = run_mid;
    record_count_next = record_count;
    result.action     = varg_pkg::ACT_IDLE;
    result.recorded   = record_count;
    unique case (mid_state)
      varg_pkg::ST_RECORDING: begin
        record_state_next = varg_pkg::ST_RECORDING;
        record_count_next = (record_count != varg_pkg::COUNT_MAX)
                          ? record_count + 1'b1 : record_count;
        result.action     = varg_pkg::ACT_WRITE;
        result.recorded   = record_count_next;
      end
      varg_pkg::ST_ENDED: begin
        result.action     = (record_count > cfg.min_record) ? varg_pkg::ACT_FINALIZE
                                                            : varg_pkg::ACT_DISCARD;
        silent_run_next   = '0;
        record_count_next = '0;
      end
      default: begin
        record_state_next = varg_pkg::ST_SILENT;
      end
    endcase
    result.voiced    = voiced;
    result.energy    = frame.energy;
    result.crossings = frame.crossings;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_state <= varg_pkg::ST_SILENT;
      silent_run   <= '0;
      record_count <= '0;
    end else if (step && frame.done) begin
      record_state <= record_state_next;
      silent_run   <= silent_run_next;
      record_count <= record_count_next;
    end
  end

endmodule

FILE: sv/voice_activity_record_gate_unit.sv
// Top level of the voice activity record gate: configuration registers,
// input and result registers. Depends on varg_pkg, varg_frame_acc, varg_rec_fsm.
//
//   Channel   Direction  Beat                          Handshake
//   sample    in         one signed audio sample       in_valid / in_stall
//   result    out        action and frame statistics   out_valid / out_stall
//   config    in         register write                cfg_write
//
// A sample is registered on acceptance and processed as it leaves the input
// register, so one sample is taken per cycle while no result is held; a
// frame-end result goes through the input register and then the result register.
// Reset is synchronous, restores register defaults and clears the valid flags,
// accumulators and recording state. A stalled result holds; one further sample
// waits in the input register before in_stall rises.
module voice_activity_record_gate_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [varg_pkg::SAMPLE_W-1:0]   sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             action,
  output logic                                   voiced,
  output logic [varg_pkg::ENERGY_W-1:0]          frame_energy,
  output logic [varg_pkg::CROSS_W-1:0]           frame_crossings,
  output logic [varg_pkg::COUNT_W-1:0]           recorded_frames,
  input  logic                                   cfg_write,
  input  logic [varg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [varg_pkg::CFG_DATA_W-1:0]        cfg_data
);

  varg_pkg::cfg_t                       cfg;
  logic                                 s_valid;
  logic signed [varg_pkg::SAMPLE_W-1:0] s_sample;
  logic                                 advance;
  logic                                 step;
  varg_pkg::frame_sum_t                 frame;
  varg_pkg::result_t                    result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_length <= varg_pkg::FRAME_LENGTH_RST;
      cfg.energy_thr   <= varg_pkg::ENERGY_THR_RST;
      cfg.cross_thr    <= varg_pkg::CROSS_THR_RST;
      cfg.silence_end  <= varg_pkg::SILENCE_END_RST;
      cfg.min_record   <= varg_pkg::MIN_RECORD_RST;
    end else if (cfg_write) begin
      unique case (varg_pkg::cfg_reg_t'(cfg_index))
        varg_pkg::REG_FRAME_LENGTH: cfg.frame_length <= cfg_data[varg_pkg::LEN_W-1:0];
        varg_pkg::REG_ENERGY_THR:   cfg.energy_thr   <= cfg_data[varg_pkg::ENERGY_W-1:0];
        varg_pkg::REG_CROSS_THR:    cfg.cross_thr    <= cfg_data[varg_pkg::CROSS_W-1:0];
        varg_pkg::REG_SILENCE_END:  cfg.silence_end  <= cfg_data[varg_pkg::COUNT_W-1:0];
        varg_pkg::REG_MIN_RECORD:   cfg.min_record   <= cfg_data[varg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the input register moves on unless a result is stuck.
  assign advance  = !(out_valid && out_stall);
  assign step     = s_valid && advance;
  assign in_stall = s_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_valid <= 1'b1;
    end else if (step) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_sample <= sample;
    end
  end

  varg_frame_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .sample       (s_sample),
    .frame_length (cfg.frame_length),
    .frame        (frame)
  );

  varg_rec_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .frame  (frame),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && frame.done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frame.done) begin
      action          <= result.action;
      voiced          <= result.voiced;
      frame_energy    <= result.energy;
      frame_crossings <= result.crossings;
      recorded_frames <= result.recorded;
    end
  end

  // A stall on the input side only ever comes from a held result.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A finalised recording is longer than the minimum.
  a_finalize_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == varg_pkg::ACT_FINALIZE)) |-> (recorded_frames > cfg.min_record))
    else $error("finalize with too few frames");

  // A written frame always counts at least one frame.
  a_write_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == varg_pkg::ACT_WRITE)) |-> (recorded_frames != '0))
    else $error("write frame with zero frame count");

endmodule
